FILE: hw/rtl/gradient_magnitude_3x3_defines.svh
// Assertion macros shared by the gradient magnitude RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef GRADIENT_MAGNITUDE_3X3_DEFINES_SVH
`define GRADIENT_MAGNITUDE_3X3_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GM3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GM3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gm3_pkg.sv
// Shared constants, register codes and types of the gradient magnitude block.
// No dependencies.
package gm3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 3;

	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int FW_W  = 11;
	localparam int FH_W  = 13;
	localparam int WIN_N = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;

	// column sums reach 3*255, differences need one more bit for the sign
	localparam int SUM3_W = PIX_W + 2;
	localparam int GRAD_W = SUM3_W + 1;
	localparam int SQ_W   = 2 * SUM3_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int ROOT_W = PIX_W;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int STEP_W = $clog2(ROOT_W);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     eol;
		logic                     eof;
	} grad_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: hw/rtl/gm3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gm3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/gm3_front.sv
// Front end: config registers, raster counters, line stores and 3x3 window.
// Produces Prewitt gradients for interior pixels. Depends on gm3_pkg, gm3_ram.
`include "gradient_magnitude_3x3_defines.svh"
module gm3_front import gm3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  push,
	output grad_t                 push_data,
	input  qstat_t                qstat
);

	localparam logic FR_IDLE = 1'b0;
	localparam logic FR_CALC = 1'b1;

	logic             state_q;
	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] win_q [WIN_N];
	logic [PIX_W-1:0] pix_q;

	logic [PIX_W-1:0] mid, top;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	logic             accept, cfg_wr, calc, interior, eol;
	logic [SUM3_W-1:0] left_sum, right_sum, upper_sum, lower_sum;

	assign cfg_ready = (state_q == FR_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;
	// a pending register write goes first; hold the pixel meanwhile
	assign in_ready  = (state_q == FR_IDLE) && !qstat.full && !cfg_valid;
	assign accept    = in_valid && in_ready;
	assign calc      = (state_q == FR_CALC);

	// the read issued on accept returns while in calc, the column is unchanged
	gm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (calc),
		.waddr (col_q),
		.wdata (mid),
		.raddr (col_q),
		.rdata (top)
	);

	gm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (calc),
		.waddr (col_q),
		.wdata (pix_q),
		.raddr (col_q),
		.rdata (mid)
	);

	always_comb begin
		if (int'(width_q) < MIN_DIM) begin
			last_col = COL_W'(MIN_DIM - 1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(width_q - 1'b1);
		end
		if (int'(height_q) < MIN_DIM) begin
			last_row = ROW_W'(MIN_DIM - 1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			last_row = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			last_row = ROW_W'(height_q - 1'b1);
		end
	end

	assign left_sum  = SUM3_W'(win_q[0]) + SUM3_W'(win_q[2]) + SUM3_W'(win_q[4]);
	assign right_sum = SUM3_W'(top) + SUM3_W'(mid) + SUM3_W'(pix_q);
	assign upper_sum = SUM3_W'(win_q[0]) + SUM3_W'(win_q[1]) + SUM3_W'(top);
	assign lower_sum = SUM3_W'(win_q[4]) + SUM3_W'(win_q[5]) + SUM3_W'(pix_q);

	assign interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
	assign eol      = (col_q == last_col);
	assign push     = calc && interior;

	always_comb begin
		push_data.gx  = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
		push_data.gy  = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
		push_data.eol = eol;
		push_data.eof = eol && (row_q == last_row);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FR_IDLE;
			width_q  <= FW_RESET;
			height_q <= FH_RESET;
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < WIN_N; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			// a write to frame width or frame height restarts the frame; other indexes do nothing
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_q <= cfg_data[FW_W-1:0];
					col_q   <= '0;
					row_q   <= '0;
					for (int i = 0; i < WIN_N; i++) begin
						win_q[i] <= '0;
					end
				end
				REG_FRAME_HEIGHT: begin
					height_q <= cfg_data[FH_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
					for (int i = 0; i < WIN_N; i++) begin
						win_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end else begin
			case (state_q)
				FR_IDLE: begin
					if (accept) begin
						state_q <= FR_CALC;
					end
				end
				FR_CALC: begin
					state_q  <= FR_IDLE;
					win_q[0] <= win_q[1];
					win_q[1] <= top;
					win_q[2] <= win_q[3];
					win_q[3] <= mid;
					win_q[4] <= win_q[5];
					win_q[5] <= pix_q;
					if (eol) begin
						col_q <= '0;
						row_q <= (row_q == last_row) ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: begin
					state_q <= FR_IDLE;
				end
			endcase
		end
	end

	`GM3_ASSERT_NOW(a_col_in_row, 1'b1, col_q <= last_col, "column count past row end")
	`GM3_ASSERT_NOW(a_row_in_frame, 1'b1, row_q <= last_row, "row count past frame end")

endmodule

FILE: hw/rtl/gm3_queue.sv
// Short FIFO of gradient pairs between the front end and the magnitude unit.
// Depends on gm3_pkg.
`include "gradient_magnitude_3x3_defines.svh"
module gm3_queue import gm3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  grad_t  push_data,
	input  logic   pop,
	output grad_t  pop_data,
	output qstat_t qstat
);

	grad_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`GM3_ASSERT_NOW(a_no_overflow, push, !qstat.full || pop, "push into full queue")
	`GM3_ASSERT_NOW(a_no_underflow, pop, !qstat.empty, "pop from empty queue")

endmodule

FILE: hw/rtl/gm3_back.sv
// Back end: squares the gradients, takes an integer square root one bit per
// cycle, saturates and holds the result in the output register. Depends on gm3_pkg.
`include "gradient_magnitude_3x3_defines.svh"
module gm3_back import gm3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qstat_t            qstat,
	input  grad_t             pop_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  magnitude,
	output logic              end_of_line,
	output logic              end_of_frame
);

	localparam logic [2:0] BK_IDLE   = 3'd0;
	localparam logic [2:0] BK_SQUARE = 3'd1;
	localparam logic [2:0] BK_SUM    = 3'd2;
	localparam logic [2:0] BK_ROOT   = 3'd3;
	localparam logic [2:0] BK_DONE   = 3'd4;

	logic [2:0]        state_q;
	grad_t             grad_q;
	logic [SQ_W-1:0]   sqx_q, sqy_q;
	logic              sat_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  mag_q;
	logic              eol_q, eof_q;

	logic signed [2*GRAD_W-1:0] prod_x, prod_y;
	logic [SUM_W-1:0]  sum;
	logic [REM_W-1:0]  rem_shift, trial;
	logic              take, load;

	assign pop    = (state_q == BK_IDLE) && !qstat.empty;
	assign load   = (state_q == BK_DONE) && (!out_valid_q || out_ready);
	assign prod_x = $signed(grad_q.gx) * $signed(grad_q.gx);
	assign prod_y = $signed(grad_q.gy) * $signed(grad_q.gy);
	assign sum    = SUM_W'(sqx_q) + SUM_W'(sqy_q);

	// bring down the next two radicand bits and try root*4+1
	assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial     = REM_W'({root_q, 2'b01});
	assign take      = (rem_shift >= trial);

	assign out_valid    = out_valid_q;
	assign magnitude    = mag_q;
	assign end_of_line  = eol_q;
	assign end_of_frame = eof_q;

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					grad_q <= pop_data;
				end
			end
			BK_SQUARE: begin
				sqx_q <= SQ_W'(prod_x);
				sqy_q <= SQ_W'(prod_y);
			end
			BK_SUM: begin
				sat_q  <= (sum[SUM_W-1:RAD_W] != '0);
				rad_q  <= sum[RAD_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			BK_ROOT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q  <= take ? rem_shift - trial : rem_shift;
				root_q <= {root_q[ROOT_W-2:0], take};
			end
			default: begin
			end
		endcase
		if (load) begin
			mag_q <= sat_q ? {PIX_W{1'b1}} : root_q;
			eol_q <= grad_q.eol;
			eof_q <= grad_q.eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= BK_SQUARE;
					end
				end
				BK_SQUARE: begin
					state_q <= BK_SUM;
				end
				BK_SUM: begin
					step_q  <= '0;
					state_q <= BK_ROOT;
				end
				BK_ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (load) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`GM3_ASSERT_NOW(a_root_bound, state_q == BK_ROOT, (root_q >> step_q) == '0,
		"partial root wider than steps taken")
	`GM3_ASSERT_NEXT(a_root_len, (state_q == BK_ROOT) && (step_q == STEP_W'(ROOT_W - 1)),
		state_q == BK_DONE, "square root did not finish after all steps")

endmodule

FILE: hw/rtl/gradient_magnitude_3x3.sv
// Top level of the 3x3 Prewitt gradient magnitude block.
// Depends on gm3_pkg, gm3_front, gm3_queue, gm3_back.
//
// Pixels enter in raster order on in_valid/in_ready/pixel. For every interior
// pixel one result leaves on out_valid/out_ready with magnitude, end_of_line
// and end_of_frame; border pixels give no result.
// frame_width (index 0) and frame_height (index 1) are written over
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is high while the front
// end waits for a pixel, a pending write goes ahead of a pixel, and a write
// to frame_width or frame_height restarts the frame.
// The front end accepts a pixel and reads the line stores while idle, then
// updates them and the window in calc, taking no pixel meanwhile. The back
// end pops a gradient pair, squares, sums, takes the root one result bit per
// cycle and loads the output register, and pops no new pair until the result
// is loaded.
// A two-entry queue between front and back lets the front keep taking pixels
// while the root is in progress or the receiver stalls; with the queue full
// in_ready drops. A stalled result holds in the output register.
// After reset the size is 640x480 and the counts and window are cleared; the
// line stores need no clearing since rows zero and one give no result.
module gradient_magnitude_3x3 import gm3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      magnitude,
	output logic                  end_of_line,
	output logic                  end_of_frame,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic   push, pop;
	grad_t  push_data, pop_data;
	qstat_t qstat;

	gm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.qstat     (qstat)
	);

	gm3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	gm3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.magnitude    (magnitude),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

endmodule

FILE: test/gradient_magnitude_3x3_tb.sv
// Self-checking testbench for the 3x3 Prewitt gradient magnitude block.
// Depends on gm3_pkg and gradient_magnitude_3x3; writes the registers, drives
// pixels and results with random idle and stall cycles and predicts every result.
module gradient_magnitude_3x3_tb import gm3_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
	localparam int TAIL_CYCLES   = 64;
	localparam int RANDOM_PIXELS = 500;

	// vertical edge, corner, flat: two saturating results and a zero
	localparam logic [PIX_W-1:0] EDGE_FRAMES [27] = '{
		8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255,
		8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	typedef enum logic [1:0] {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pix_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0] magnitude;
		logic             end_of_line;
		logic             end_of_frame;
	} gradient_result_t;

	class magnitude_predictor;
		int unsigned        width_reg;
		int unsigned        height_reg;
		logic [PIX_W-1:0]   older_row [MAX_WIDTH];
		logic [PIX_W-1:0]   newer_row [MAX_WIDTH];
		logic [PIX_W-1:0]   window [WIN_N];
		int unsigned        col;
		int unsigned        row;
		gradient_result_t   expected_magnitudes [$];
		int                 errors;

		function new();
			width_reg = FW_RESET;
			height_reg = FH_RESET;
			errors = 0;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			restart();
		endfunction

		function void restart();
			col = 0;
			row = 0;
			foreach (window[i]) window[i] = '0;
		endfunction

		function int unsigned active_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned active_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = data[FW_W-1:0];
					restart();
				end
				REG_FRAME_HEIGHT: begin
					height_reg = data[FH_W-1:0];
					restart();
				end
				default: ;
			endcase
		endfunction

		// floor of the square root, one result bit at a time from the top
		function int unsigned floor_root(int unsigned energy);
			int unsigned root;
			int unsigned trial;
			root = 0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				trial = root | (1 << b);
				if (trial * trial <= energy) root = trial;
			end
			return root;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] bottom);
			int unsigned      w;
			int unsigned      h;
			logic [PIX_W-1:0] top;
			logic [PIX_W-1:0] mid;
			int               gx;
			int               gy;
			int unsigned      energy;
			gradient_result_t res;
			w = active_width();
			h = active_height();
			top = older_row[col];
			mid = newer_row[col];
			if (row >= 2 && col >= 2) begin
				gx = (int'(top) + int'(mid) + int'(bottom))
					- (int'(window[0]) + int'(window[2]) + int'(window[4]));
				gy = (int'(window[4]) + int'(window[5]) + int'(bottom))
					- (int'(window[0]) + int'(window[1]) + int'(top));
				energy = gx * gx + gy * gy;
				res.magnitude = (energy >= 65536) ? 8'd255 : PIX_W'(floor_root(energy));
				res.end_of_line = (col == w - 1);
				res.end_of_frame = res.end_of_line && (row == h - 1);
				expected_magnitudes.push_back(res);
			end
			older_row[col] = mid;
			newer_row[col] = bottom;
			window[0] = window[1];
			window[1] = top;
			window[2] = window[3];
			window[3] = mid;
			window[4] = window[5];
			window[5] = bottom;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] mag, logic eol, logic eof);
			gradient_result_t want;
			if (expected_magnitudes.size() == 0) begin
				$error("unexpected result: magnitude %0d end_of_line %b end_of_frame %b",
					mag, eol, eof);
				errors++;
				return;
			end
			want = expected_magnitudes.pop_front();
			if (mag !== want.magnitude) begin
				$error("magnitude: expected %0d, got %0d", want.magnitude, mag);
				errors++;
			end
			if (eol !== want.end_of_line) begin
				$error("end_of_line: expected %b, got %b", want.end_of_line, eol);
				errors++;
			end
			if (eof !== want.end_of_frame) begin
				$error("end_of_frame: expected %b, got %b", want.end_of_frame, eof);
				errors++;
			end
		endfunction

		function int pending();
			return expected_magnitudes.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      magnitude;
	logic                  end_of_line;
	logic                  end_of_frame;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit               tx_no_idle = 1'b0;
	bit               rx_no_stall = 1'b0;
	logic [PIX_W-1:0] last_pixel = '0;

	magnitude_predictor frame_model = new();

	gradient_magnitude_3x3 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.magnitude    (magnitude),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// every transfer is seen here, in order, with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) frame_model.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) frame_model.note_pixel(pixel);
			if (out_valid && out_ready)
				frame_model.check_result(magnitude, end_of_line, end_of_frame);
		end
	end

	// result receiver: stall a random number of cycles before each transfer
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_no_stall ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [PIX_W-1:0] draw_pixel(pix_mode_t mode, logic [PIX_W-1:0] prev);
		int next;
		case (mode)
			PIX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			PIX_SMOOTH: begin
				next = int'(prev) + int'($urandom_range(0, 8)) - 4;
				if (next < 0) next = 0;
				if (next > 255) next = 255;
				return PIX_W'(next);
			end
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// leaves in_valid high after the transfer; the next call or drain settles it
	task automatic send_pixel(input logic [PIX_W-1:0] value);
		int unsigned gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stream_pixels(input int unsigned count, input pix_mode_t mode);
		for (int unsigned i = 0; i < count; i++) begin
			last_pixel = draw_pixel(mode, last_pixel);
			send_pixel(last_pixel);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold input low until every result is out, then through the tail wait as well
	task automatic drain();
		in_valid <= 1'b0;
		while (frame_model.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned      random_count;
		int unsigned      frame_pixels;
		int unsigned      count;
		int unsigned      split;
		logic [CFG_DATA_W-1:0] wdata;
		logic [CFG_DATA_W-1:0] hdata;
		pix_mode_t        mode;
		bit               big;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: a short run inside the first row gives no result
		stream_pixels(40, PIX_UNIFORM);
		drain();

		// widths and heights below range act as 3
		write_register(REG_FRAME_WIDTH, 13'd0);
		write_register(REG_FRAME_HEIGHT, 13'd0);
		foreach (EDGE_FRAMES[i]) send_pixel(EDGE_FRAMES[i]);
		drain();

		// all data bits set: width clamps to the maximum, the run stays in row zero
		write_register(REG_FRAME_WIDTH, 13'h1FFF);
		write_register(REG_FRAME_HEIGHT, 13'd3);
		stream_pixels(40, PIX_UNIFORM);
		drain();

		// height above range; unknown indexes mid-frame must not restart it
		write_register(REG_FRAME_WIDTH, 13'd2);
		write_register(REG_FRAME_HEIGHT, 13'h1FFF);
		stream_pixels(30, PIX_SMOOTH);
		drain();
		write_register(REG_UNUSED_2, CFG_DATA_W'($urandom_range(0, 8191)));
		stream_pixels(30, PIX_EXTREME);
		drain();
		write_register(REG_UNUSED_3, CFG_DATA_W'($urandom_range(0, 8191)));
		stream_pixels(9, PIX_UNIFORM);
		drain();

		// tallest frame, first rows back to back
		write_register(REG_FRAME_HEIGHT, 13'd4096);
		tx_no_idle = 1'b1;
		stream_pixels(60, PIX_UNIFORM);
		tx_no_idle = 1'b0;
		drain();

		random_count = 0;
		while (random_count < RANDOM_PIXELS) begin
			big = ($urandom_range(0, 7) == 0);
			if (big) begin
				wdata = CFG_DATA_W'($urandom_range(0, 8191));
				hdata = CFG_DATA_W'($urandom_range(0, 8191));
			end else begin
				// upper data bits of a width write are ignored
				wdata = CFG_DATA_W'($urandom_range(0, 9) == 0 ?
					$urandom_range(0, 3) : $urandom_range(3, 12));
				wdata[12:11] = 2'($urandom_range(0, 3));
				hdata = CFG_DATA_W'($urandom_range(0, 9) == 0 ?
					$urandom_range(0, 3) : $urandom_range(3, 8));
			end
			if ($urandom_range(0, 1)) begin
				write_register(REG_FRAME_WIDTH, wdata);
				write_register(REG_FRAME_HEIGHT, hdata);
			end else begin
				write_register(REG_FRAME_HEIGHT, hdata);
				write_register(REG_FRAME_WIDTH, wdata);
			end

			frame_pixels = frame_model.active_width() * frame_model.active_height();
			if (big)
				count = $urandom_range(5, 40);
			else if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, frame_pixels - 1);
			else
				count = frame_pixels * $urandom_range(1, 2);

			mode = pix_mode_t'($urandom_range(0, 2));
			tx_no_idle = ($urandom_range(0, 3) == 0);
			rx_no_stall = ($urandom_range(0, 3) == 0);

			if (count > 2 && $urandom_range(0, 5) == 0) begin
				split = $urandom_range(1, count - 1);
				stream_pixels(split, mode);
				drain();
				write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					CFG_DATA_W'($urandom_range(0, 8191)));
				stream_pixels(count - split, mode);
			end else begin
				stream_pixels(count, mode);
			end
			drain();
			random_count += count;
		end

		tx_no_idle = 1'b0;
		rx_no_stall = 1'b0;
		drain();
		if (frame_model.errors == 0 && frame_model.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
